FILE: rtl/core/pfa_pkg.sv
package pfa_pkg;

    // Field widths of the stream words and the configuration port.
    localparam int OPCODE_W  = 2;
    localparam int ADDR_W    = 32;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 1;

    // Bit positions inside the stream words.
    localparam int S_ADDR_LSB    = OPCODE_W;
    localparam int M_GRANTED_BIT = ADDR_W;
    localparam int M_DROPPED_BIT = ADDR_W + 1;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_INIT  = 2'd2
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RAM_START = 1'd0,
        REG_RAM_END   = 1'd1
    } cfg_reg_t;

endpackage

FILE: rtl/core/pfa_ram.sv
module pfa_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Read returns the old contents when the same entry is written in that cycle.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/page_frame_allocator_top.sv
// A result word appears in the cycle after its request word is accepted.
// Throughput: one request word per cycle; s_tready is low only while a finished
// result waits on m_tready.
// Reset (aresetn, synchronous, active low) empties the region and the free-page
// FIFO and clears both configuration registers; the FIFO memory is not cleared.
module page_frame_allocator_top #(
    parameter int PAGE_SHIFT = 12,
    parameter int FREE_DEPTH = 1024,
    parameter int ADDR_BITS  = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wen,
    input  logic [pfa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pfa_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // opcode [1:0], free_address [33:2], zero fill [39:34]
    input  logic [pfa_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // page_address [31:0], granted [32], free_dropped [33], zero fill [39:34]
    output logic [pfa_pkg::M_TDATA_W-1:0] m_tdata
);

    import pfa_pkg::*;

    localparam int AW    = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
    localparam int PN_W  = (AW > PAGE_SHIFT) ? AW - PAGE_SHIFT : 1;
    localparam int PX_W  = PN_W + PAGE_SHIFT;
    localparam int CW    = (AW > PAGE_SHIFT + 1) ? AW : PAGE_SHIFT + 1;
    localparam int PTR_W = $clog2(FREE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    logic [CFG_W-1:0] ram_start_reg;
    logic [CFG_W-1:0] ram_end_reg;

    logic [AW-1:0]    region_next_reg, region_next_next;
    logic [AW-1:0]    region_left_reg, region_left_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic             byp_valid_reg, byp_valid_next;
    logic [PN_W-1:0]  byp_data_reg;

    logic             m_valid_reg, m_valid_next;
    logic [AW-1:0]    page_reg, page_next;
    logic             granted_reg, granted_next;
    logic             dropped_reg, dropped_next;

    logic             s_fire;
    opcode_t          opcode;
    logic [AW-1:0]    addr_aw;
    logic [PN_W-1:0]  addr_sh;
    logic             fifo_full;
    logic             ram_wr_en;
    logic [PN_W-1:0]  ram_wr_data;
    logic [PN_W-1:0]  ram_rd_data;
    logic [PN_W-1:0]  head_pn;
    logic [PX_W-1:0]  head_px;
    logic [CW-1:0]    left_ext;
    logic [CW-1:0]    pg_bytes;
    logic [CW-1:0]    step_sum;
    logic [CW-1:0]    step_left;
    logic [AW-1:0]    cfg_s;
    logic [AW-1:0]    cfg_e;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(FREE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    assign s_tready = !m_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;
    assign opcode   = opcode_t'(s_tdata[OPCODE_W-1:0]);
    assign addr_aw  = s_tdata[S_ADDR_LSB +: AW];
    assign addr_sh  = PN_W'(addr_aw >> PAGE_SHIFT);

    assign fifo_full   = (count_reg == CNT_W'(FREE_DEPTH));
    assign ram_wr_en   = s_fire && (opcode == OP_FREE) && !fifo_full;
    assign ram_wr_data = addr_sh;

    // The RAM is always reading the entry that will be the head next cycle;
    // a push into that very entry is caught by the bypass register.
    assign head_pn = byp_valid_reg ? byp_data_reg : ram_rd_data;
    assign head_px = PX_W'(head_pn) << PAGE_SHIFT;

    assign left_ext  = CW'(region_left_reg);
    assign pg_bytes  = CW'(1) << PAGE_SHIFT;
    assign step_sum  = CW'(region_next_reg) + pg_bytes;
    assign step_left = left_ext - pg_bytes;
    assign cfg_s     = ram_start_reg[AW-1:0];
    assign cfg_e     = ram_end_reg[AW-1:0];

    pfa_ram #(
        .WIDTH (PN_W),
        .DEPTH (FREE_DEPTH)
    ) u_free_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (wr_ptr_reg),
        .wr_data (ram_wr_data),
        .rd_addr (rd_ptr_next),
        .rd_data (ram_rd_data)
    );

    always_comb begin
        region_next_next = region_next_reg;
        region_left_next = region_left_reg;
        rd_ptr_next      = rd_ptr_reg;
        wr_ptr_next      = wr_ptr_reg;
        count_next       = count_reg;
        page_next        = page_reg;
        granted_next     = granted_reg;
        dropped_next     = dropped_reg;
        m_valid_next     = m_tready ? 1'b0 : m_valid_reg;

        if (s_fire) begin
            m_valid_next = 1'b1;
            page_next    = '0;
            granted_next = 1'b0;
            dropped_next = 1'b0;
            case (opcode)
                OP_ALLOC: begin
                    if (region_left_reg != '0) begin
                        page_next    = region_next_reg;
                        granted_next = 1'b1;
                        if (left_ext > pg_bytes) begin
                            region_next_next = step_sum[AW-1:0];
                            region_left_next = step_left[AW-1:0];
                        end else begin
                            // The remainder of one page or less goes out whole.
                            region_left_next = '0;
                        end
                    end else if (count_reg != '0) begin
                        page_next    = head_px[AW-1:0];
                        granted_next = 1'b1;
                        rd_ptr_next  = ptr_inc(rd_ptr_reg);
                        count_next   = count_reg - 1'b1;
                    end
                end
                OP_FREE: begin
                    if (fifo_full) begin
                        dropped_next = 1'b1;
                    end else begin
                        wr_ptr_next = ptr_inc(wr_ptr_reg);
                        count_next  = count_reg + 1'b1;
                    end
                end
                OP_INIT: begin
                    region_next_next = cfg_s;
                    region_left_next = (cfg_e > cfg_s) ? cfg_e - cfg_s : '0;
                    rd_ptr_next      = '0;
                    wr_ptr_next      = '0;
                    count_next       = '0;
                end
                default: begin
                end
            endcase
        end

        byp_valid_next = ram_wr_en && (wr_ptr_reg == rd_ptr_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ram_start_reg   <= '0;
            ram_end_reg     <= '0;
            region_next_reg <= '0;
            region_left_reg <= '0;
            rd_ptr_reg      <= '0;
            wr_ptr_reg      <= '0;
            count_reg       <= '0;
            byp_valid_reg   <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wen) begin
                case (cfg_reg_t'(cfg_index))
                    REG_RAM_START: ram_start_reg <= cfg_wdata;
                    REG_RAM_END:   ram_end_reg   <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            region_next_reg <= region_next_next;
            region_left_reg <= region_left_next;
            rd_ptr_reg      <= rd_ptr_next;
            wr_ptr_reg      <= wr_ptr_next;
            count_reg       <= count_next;
            byp_valid_reg   <= byp_valid_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byp_data_reg <= ram_wr_data;
        page_reg     <= page_next;
        granted_reg  <= granted_next;
        dropped_reg  <= dropped_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - ADDR_W - 2){1'b0}}, dropped_reg, granted_reg,
                       ADDR_W'(page_reg)};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(FREE_DEPTH))
        else $error("free-page count beyond FIFO depth");

    a_grant_drop_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(granted_reg && dropped_reg))
        else $error("result word both granted and dropped");

    a_no_grant_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !granted_reg) |-> (page_reg == '0))
        else $error("page address not zero without a grant");

    a_full_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && opcode == OP_FREE && fifo_full) |=> (m_valid_reg && dropped_reg))
        else $error("free into a full FIFO not flagged as dropped");

endmodule

FILE: verif/page_frame_allocator_top_tb.sv
`timescale 1ns / 100ps

module page_frame_allocator_top_tb;
    import pfa_pkg::*;

    localparam int PAGE_SHIFT     = 12;
    localparam int FREE_DEPTH     = 1024;
    localparam int ADDR_BITS      = 32;
    localparam int RANDOM_ITEMS   = 1525;
    localparam int RX_HOLD_CYCLES = 200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int STEADY_PHASE   = 1;
    localparam int FILL_PHASE     = 3;

    localparam logic [1:0]  OP_UNUSED  = 2'd3;
    localparam logic [32:0] PAGE_BYTES = 33'd1 << PAGE_SHIFT;

    typedef struct packed {
        logic [ADDR_W-1:0] page_address;
        logic              granted;
        logic              free_dropped;
    } page_result_t;

    localparam page_result_t NO_GRANT = '0;

    typedef enum bit {ROW_WORD, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t         kind;
        logic [1:0]        opcode;
        cfg_reg_t          reg_sel;
        logic [ADDR_W-1:0] value;
        bit                typed;
        page_result_t      result;
    } stim_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_wen;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    // opcode [1:0], free_address [33:2], zero fill [39:34]
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    // page_address [31:0], granted [32], free_dropped [33], zero fill [39:34]
    logic [M_TDATA_W-1:0] m_tdata;

    // Shadow of the allocator: registers, bump region and free-page list.
    logic [ADDR_W-1:0]             cfg_ram_start = '0;
    logic [ADDR_W-1:0]             cfg_ram_end   = '0;
    logic [ADDR_W-1:0]             bump_next     = '0;
    logic [ADDR_W:0]               bump_left     = '0;
    logic [ADDR_W-PAGE_SHIFT-1:0]  freed_page_num [FREE_DEPTH];
    logic [$clog2(FREE_DEPTH)-1:0] free_rd       = '0;
    logic [$clog2(FREE_DEPTH)-1:0] free_wr       = '0;
    int unsigned                   free_count    = 0;

    page_result_t pending_results [$];
    int unsigned  mismatch_count = 0;
    bit           steady_phase   = 1'b0;
    bit           hold_rx        = 1'b0;

    stim_row_t directed_rows [30] = '{
        '{ROW_WORD, OP_ALLOC,  REG_RAM_START, 32'h0000_0000, 1'b1, NO_GRANT},
        '{ROW_WORD, OP_UNUSED, REG_RAM_START, 32'hFFFF_FFFF, 1'b1, NO_GRANT},
        '{ROW_WORD, OP_INIT,   REG_RAM_START, 32'h0000_0000, 1'b1, NO_GRANT},
        '{ROW_WORD, OP_ALLOC,  REG_RAM_START, 32'h0000_0000, 1'b1, NO_GRANT},
        '{ROW_REG,  OP_ALLOC,  REG_RAM_START, 32'h0000_1000, 1'b0, NO_GRANT},
        '{ROW_REG,  OP_ALLOC,  REG_RAM_END,   32'h0000_3800, 1'b0, NO_GRANT},
        '{ROW_WORD, OP_INIT,   REG_RAM_START, 32'h0000_0000, 1'b1, NO_GRANT},
        '{ROW_WORD, OP_ALLOC,  REG_RAM_START, 32'h0, 1'b1, '{32'h0000_1000, 1'b1, 1'b0}},
        '{ROW_WORD, OP_ALLOC,  REG_RAM_START, 32'h0, 1'b1, '{32'h0000_2000, 1'b1, 1'b0}},
        '{ROW_WORD, OP_ALLOC,  REG_RAM_START, 32'h0, 1'b1, '{32'h0000_3000, 1'b1, 1'b0}},
        '{ROW_WORD, OP_ALLOC,  REG_RAM_START, 32'h0000_0000, 1'b1, NO_GRANT},
        '{ROW_WORD, OP_FREE,   REG_RAM_START, 32'hFFFF_FFFF, 1'b1, NO_GRANT},
        '{ROW_WORD, OP_FREE,   REG_RAM_START, 32'h0000_0000, 1'b1, NO_GRANT},
        '{ROW_WORD, OP_FREE,   REG_RAM_START, 32'h1234_5ABC, 1'b1, NO_GRANT},
        '{ROW_WORD, OP_ALLOC,  REG_RAM_START, 32'h0, 1'b1, '{32'hFFFF_F000, 1'b1, 1'b0}},
        '{ROW_WORD, OP_ALLOC,  REG_RAM_START, 32'h0, 1'b1, '{32'h0000_0000, 1'b1, 1'b0}},
        '{ROW_WORD, OP_ALLOC,  REG_RAM_START, 32'h0000_0000, 1'b0, NO_GRANT},
        '{ROW_WORD, OP_ALLOC,  REG_RAM_START, 32'h0000_0000, 1'b1, NO_GRANT},
        '{ROW_REG,  OP_ALLOC,  REG_RAM_START, 32'hFFFF_F123, 1'b0, NO_GRANT},
        '{ROW_REG,  OP_ALLOC,  REG_RAM_END,   32'hFFFF_FFFF, 1'b0, NO_GRANT},
        '{ROW_WORD, OP_INIT,   REG_RAM_START, 32'h0000_0000, 1'b1, NO_GRANT},
        '{ROW_WORD, OP_ALLOC,  REG_RAM_START, 32'h0, 1'b1, '{32'hFFFF_F123, 1'b1, 1'b0}},
        '{ROW_WORD, OP_ALLOC,  REG_RAM_START, 32'h0000_0000, 1'b1, NO_GRANT},
        '{ROW_WORD, OP_FREE,   REG_RAM_START, 32'hAAAA_5555, 1'b0, NO_GRANT},
        '{ROW_REG,  OP_ALLOC,  REG_RAM_END,   32'h0000_0000, 1'b0, NO_GRANT},
        '{ROW_WORD, OP_INIT,   REG_RAM_START, 32'h0000_0000, 1'b1, NO_GRANT},
        '{ROW_WORD, OP_ALLOC,  REG_RAM_START, 32'h0000_0000, 1'b1, NO_GRANT},
        '{ROW_WORD, OP_FREE,   REG_RAM_START, 32'h5555_AAAA, 1'b0, NO_GRANT},
        '{ROW_WORD, OP_UNUSED, REG_RAM_START, 32'h0000_0000, 1'b1, NO_GRANT},
        '{ROW_WORD, OP_ALLOC,  REG_RAM_START, 32'h0000_0000, 1'b0, NO_GRANT}
    };

    page_frame_allocator_top #(
        .PAGE_SHIFT (PAGE_SHIFT),
        .FREE_DEPTH (FREE_DEPTH),
        .ADDR_BITS  (ADDR_BITS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic page_result_t predict_page_result(input logic [1:0]        op,
                                                         input logic [ADDR_W-1:0] addr);
        page_result_t res;
        res = '0;
        case (op)
            OP_ALLOC: begin
                if (bump_left != '0) begin
                    res.page_address = bump_next;
                    res.granted      = 1'b1;
                    // A remainder of one page or less goes out whole.
                    if (bump_left > PAGE_BYTES) begin
                        bump_next = bump_next + PAGE_BYTES[ADDR_W-1:0];
                        bump_left = bump_left - PAGE_BYTES;
                    end else begin
                        bump_left = '0;
                    end
                end else if (free_count != 0) begin
                    res.page_address = {freed_page_num[free_rd], {PAGE_SHIFT{1'b0}}};
                    res.granted      = 1'b1;
                    free_rd++;
                    free_count--;
                end
            end
            OP_FREE: begin
                if (free_count == FREE_DEPTH) begin
                    res.free_dropped = 1'b1;
                end else begin
                    freed_page_num[free_wr] = addr[ADDR_W-1:PAGE_SHIFT];
                    free_wr++;
                    free_count++;
                end
            end
            OP_INIT: begin
                bump_next = cfg_ram_start;
                if (cfg_ram_end > cfg_ram_start)
                    bump_left = {1'b0, cfg_ram_end} - {1'b0, cfg_ram_start};
                else
                    bump_left = '0;
                free_rd    = '0;
                free_wr    = '0;
                free_count = 0;
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("%0t: mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic send_request(input logic [1:0]        op,
                                input logic [ADDR_W-1:0] addr,
                                input bit                typed,
                                input page_result_t      typed_result);
        int unsigned  gap;
        page_result_t predicted;
        gap = 0;
        while (!steady_phase && $urandom_range(99) < 28)
            gap++;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - ADDR_W - OPCODE_W){1'b0}}, addr, op};
        @(posedge aclk);
        while (s_tready !== 1'b1)
            @(posedge aclk);
        predicted = predict_page_result(op, addr);
        pending_results.push_back(typed ? typed_result : predicted);
    endtask

    task automatic wait_until_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_register(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
        wait_until_drained();
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        if (idx == REG_RAM_START)
            cfg_ram_start = val;
        else
            cfg_ram_end = val;
        @(posedge aclk);
    endtask

    always @(posedge aclk) begin : result_check
        page_result_t want;
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            if (pending_results.size() == 0) begin
                flag_mismatch($sformatf("unexpected result word %h", m_tdata));
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[ADDR_W-1:0] !== want.page_address)
                    flag_mismatch($sformatf("page_address %h, expected %h",
                                            m_tdata[ADDR_W-1:0], want.page_address));
                if (m_tdata[M_GRANTED_BIT] !== want.granted)
                    flag_mismatch($sformatf("granted %b, expected %b",
                                            m_tdata[M_GRANTED_BIT], want.granted));
                if (m_tdata[M_DROPPED_BIT] !== want.free_dropped)
                    flag_mismatch($sformatf("free_dropped %b, expected %b",
                                            m_tdata[M_DROPPED_BIT], want.free_dropped));
            end
        end
    end

    initial begin : receiver
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_rx) begin
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
                hold_rx = 1'b0;
            end
            m_tready <= steady_phase || ($urandom_range(99) >= 28);
            @(posedge aclk);
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid === 1'b1 && s_tready === 1'b1) ||
                (m_tvalid === 1'b1 && m_tready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("page_frame_allocator_top_tb failed");
        $finish;
    end

    initial begin : stimulus
        int unsigned       phase;
        int unsigned       random_items;
        int unsigned       pick;
        logic [1:0]        op;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] region_lo;
        logic [ADDR_W-1:0] region_hi;

        phase        = 0;
        random_items = 0;
        aresetn   <= 1'b0;
        cfg_wen   <= 1'b0;
        cfg_index <= REG_RAM_START;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_REG)
                write_register(directed_rows[i].reg_sel, directed_rows[i].value);
            else
                send_request(directed_rows[i].opcode, directed_rows[i].value,
                             directed_rows[i].typed, directed_rows[i].result);
        end

        while (random_items < RANDOM_ITEMS) begin
            if (phase == 0) begin
                region_lo = '0;
                region_hi = '1;
            end else if (phase == FILL_PHASE) begin
                // An empty region, so that no alloc is served from the region and the frees fill the list.
                region_lo = $urandom;
                region_hi = region_lo;
            end else begin
                case ($urandom_range(0, 4))
                    0: begin
                        region_lo = '0;
                        region_hi = $urandom_range(0, 5 << PAGE_SHIFT);
                    end
                    1: begin
                        region_lo = 32'hFFFF_F000 - ($urandom_range(0, 4) << PAGE_SHIFT);
                        region_hi = '1;
                    end
                    2: begin
                        region_lo = $urandom;
                        region_hi = $urandom;
                    end
                    default: begin
                        region_lo = {(ADDR_W - PAGE_SHIFT)'($urandom_range(0, 20'hF_FFFF)),
                                     {PAGE_SHIFT{1'b0}}};
                        if ($urandom_range(0, 3) == 0)
                            region_lo[PAGE_SHIFT-1:0] = PAGE_SHIFT'($urandom);
                        region_hi = region_lo + $urandom_range(0, (6 << PAGE_SHIFT) + 100);
                    end
                endcase
            end
            write_register(REG_RAM_START, region_lo);
            write_register(REG_RAM_END, region_hi);
            send_request(OP_INIT, $urandom, 1'b0, NO_GRANT);
            random_items++;

            if (phase == FILL_PHASE) begin
                // The receiver stops for a long while, and the frees stall behind it; the
                // list then overflows and the last 8 of the FREE_DEPTH + 8 frees are dropped.
                hold_rx = 1'b1;
                repeat (FREE_DEPTH + 8) begin
                    send_request(OP_FREE, $urandom, 1'b0, NO_GRANT);
                    random_items++;
                end
                repeat (40) begin
                    op = $urandom_range(0, 1) ? OP_ALLOC : OP_FREE;
                    send_request(op, $urandom, 1'b0, NO_GRANT);
                    random_items++;
                end
            end else begin
                steady_phase = (phase == STEADY_PHASE);
                repeat (steady_phase ? 150 : $urandom_range(20, 60)) begin
                    pick = $urandom_range(99);
                    if (pick < 48)
                        op = OP_ALLOC;
                    else if (pick < 90)
                        op = OP_FREE;
                    else if (pick < 95)
                        op = OP_INIT;
                    else
                        op = OP_UNUSED;
                    if ($urandom_range(0, 3) == 0)
                        addr = region_lo + $urandom_range(0, 8 << PAGE_SHIFT);
                    else
                        addr = $urandom;
                    send_request(op, addr, 1'b0, NO_GRANT);
                    if (op != OP_UNUSED)
                        random_items++;
                end
                steady_phase = 1'b0;
            end
            phase++;
        end

        wait_until_drained();
        repeat (4) @(posedge aclk);
        if (mismatch_count == 0)
            $display("page_frame_allocator_top_tb passed");
        else
            $display("page_frame_allocator_top_tb failed");
        $finish;
    end

endmodule
